// File: src/mcs51_data_move_unit_assert.svh
// Assertion macros for the data-move unit
`ifndef MCS51_DATA_MOVE_UNIT_ASSERT_SVH
`define MCS51_DATA_MOVE_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check that cons holds in the cycle after ante
`define MDM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("data-move unit check failed");
// Check that cons holds in the same cycle as ante
`define MDM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("data-move unit check failed");
`else
`define MDM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define MDM_ASSERT_NOW(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/mdm_pkg.sv
package mdm_pkg;

  localparam logic [7:0] SFR_ACC = 8'hE0;
  localparam logic [7:0] SFR_PSW = 8'hD0;
  localparam logic [7:0] SFR_DPL = 8'h82;
  localparam logic [7:0] SFR_DPH = 8'h83;
  localparam int MEM_BYTES = 256;
  localparam int REG_BYTES = 32;
  // First address above the four register banks
  localparam logic [7:0] REG_LIMIT = 8'h20;
  localparam logic [7:0] CLEAR_LAST = 8'hFF;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_OP  = 2'd1,
    ST_PENDING = 2'd2,
    ST_PROTO   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_RN_IMM, OP_A_RN, OP_RN_A, OP_RN_DIR, OP_DIR_RN,
    OP_A_IMM, OP_A_DIR, OP_DIR_A, OP_DIR_DIR, OP_DIR_IMM,
    OP_IND_IMM, OP_A_IND, OP_IND_A, OP_IND_DIR, OP_DIR_IND,
    OP_DPTR_IMM, OP_C_BIT, OP_BIT_C, OP_MOVC_DPTR, OP_MOVC_PC, OP_BAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [1:0] cycles;
  } dec_t;

endpackage

// File: src/mdm_decode.sv
module mdm_decode (
  input  logic [7:0]   opcode,
  output mdm_pkg::dec_t dec
);

  // Classify the opcode and charge its machine cycles
  always_comb begin
    dec.kind   = mdm_pkg::OP_BAD;
    dec.cycles = 2'd0;
    case (opcode[7:3])
      5'b01111: begin dec.kind = mdm_pkg::OP_RN_IMM; dec.cycles = 2'd1; end
      5'b11101: begin dec.kind = mdm_pkg::OP_A_RN;   dec.cycles = 2'd1; end
      5'b11111: begin dec.kind = mdm_pkg::OP_RN_A;   dec.cycles = 2'd1; end
      5'b10101: begin dec.kind = mdm_pkg::OP_RN_DIR; dec.cycles = 2'd2; end
      5'b10001: begin dec.kind = mdm_pkg::OP_DIR_RN; dec.cycles = 2'd2; end
      default: begin
        unique case (opcode)
          8'h00: begin dec.kind = mdm_pkg::OP_NOP;      dec.cycles = 2'd1; end
          8'h74: begin dec.kind = mdm_pkg::OP_A_IMM;    dec.cycles = 2'd1; end
          8'hE5: begin dec.kind = mdm_pkg::OP_A_DIR;    dec.cycles = 2'd1; end
          8'hF5: begin dec.kind = mdm_pkg::OP_DIR_A;    dec.cycles = 2'd1; end
          8'h85: begin dec.kind = mdm_pkg::OP_DIR_DIR;  dec.cycles = 2'd2; end
          8'h75: begin dec.kind = mdm_pkg::OP_DIR_IMM;  dec.cycles = 2'd2; end
          8'h76, 8'h77: begin dec.kind = mdm_pkg::OP_IND_IMM; dec.cycles = 2'd1; end
          8'hE6, 8'hE7: begin dec.kind = mdm_pkg::OP_A_IND;   dec.cycles = 2'd1; end
          8'hF6, 8'hF7: begin dec.kind = mdm_pkg::OP_IND_A;   dec.cycles = 2'd1; end
          8'hA6, 8'hA7: begin dec.kind = mdm_pkg::OP_IND_DIR; dec.cycles = 2'd2; end
          8'h86, 8'h87: begin dec.kind = mdm_pkg::OP_DIR_IND; dec.cycles = 2'd2; end
          8'h90: begin dec.kind = mdm_pkg::OP_DPTR_IMM;  dec.cycles = 2'd2; end
          8'hA2: begin dec.kind = mdm_pkg::OP_C_BIT;     dec.cycles = 2'd1; end
          8'h92: begin dec.kind = mdm_pkg::OP_BIT_C;     dec.cycles = 2'd1; end
          8'h93: begin dec.kind = mdm_pkg::OP_MOVC_DPTR; dec.cycles = 2'd2; end
          8'h83: begin dec.kind = mdm_pkg::OP_MOVC_PC;   dec.cycles = 2'd2; end
          default: begin dec.kind = mdm_pkg::OP_BAD;     dec.cycles = 2'd0; end
        endcase
      end
    endcase
  end

endmodule

// File: src/mcs51_data_move_unit.sv
// Words pass the input register, then the result register; both free as words are taken.
// Throughput: one word per cycle, unless out_stall holds the result or the clear stalls the input.
// Register banks, A, PSW and DPTR are flip-flops; all other bytes sit in a memory
// with one registered read and one write per cycle.
// Reset: synchronous, active high; the memory then clears every byte from 0 to 0xFF with the
// input stalled.
`include "mcs51_data_move_unit_assert.svh"

module mcs51_data_move_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  opcode,
  input  logic [7:0]  operand_first,
  input  logic [7:0]  operand_second,
  input  logic [15:0] next_pc,
  input  logic [7:0]  code_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  cycles,
  output logic [15:0] code_address,
  output logic [7:0]  acc_value,
  output logic [7:0]  psw_value,
  output logic [15:0] dptr_value,
  output logic [47:0] time_total
);

  logic [7:0]    mem [mdm_pkg::MEM_BYTES];
  logic [7:0]    regs [mdm_pkg::REG_BYTES];
  logic [7:0]    acc, psw, dpl, dph;
  logic          pending;
  logic [47:0]   total;
  logic          clearing;
  logic [7:0]    clr_addr;
  mdm_pkg::dec_t dec;

  logic          s1_valid;
  logic          s1_command;
  logic [7:0]    s1_opcode, s1_first, s1_second, s1_code;
  logic [15:0]   s1_pc;
  mdm_pkg::dec_t s1_dec;
  logic [7:0]    s1_rd_addr;
  logic [7:0]    rd_q;
  logic          byp_hit;
  logic [7:0]    byp_data;

  logic          accept, adv;
  logic [7:0]    psw_fwd, ri_addr_in, ri_fwd, bb_addr_in, rd_addr_in;
  logic [7:0]    rn_addr, ri_addr, rn_val, ri_val, rd_val;
  logic [7:0]    bit_mask;
  logic          bit_val;
  logic          wen, dptr_wen, pending_next;
  logic [7:0]    waddr, wdata;
  logic [1:0]    cyc;
  logic [15:0]   caddr;
  mdm_pkg::status_t st;
  logic [47:0]   total_next;
  logic [7:0]    acc_next, psw_next, dpl_next, dph_next;

  mdm_decode u_decode (
    .opcode (opcode),
    .dec    (dec)
  );

  assign adv      = s1_valid && !(out_valid && out_stall);
  assign in_stall = clearing || (s1_valid && !adv);
  assign accept   = in_valid && !in_stall;

  // Pick the byte address the incoming word reads, with the retiring write applied
  always_comb begin
    psw_fwd    = (adv && wen && waddr == mdm_pkg::SFR_PSW) ? wdata : psw;
    ri_addr_in = {3'b000, psw_fwd[4:3], 2'b00, opcode[0]};
    ri_fwd     = (adv && wen && waddr == ri_addr_in) ? wdata : regs[ri_addr_in[4:0]];
    bb_addr_in = operand_first[7] ? {operand_first[7:3], 3'b000}
                                  : {4'b0010, operand_first[6:3]};
    case (dec.kind) inside
      mdm_pkg::OP_A_IND, mdm_pkg::OP_DIR_IND: rd_addr_in = ri_fwd;
      mdm_pkg::OP_C_BIT, mdm_pkg::OP_BIT_C:   rd_addr_in = bb_addr_in;
      default:                                rd_addr_in = operand_first;
    endcase
  end

  // Fetch the operands of the word in the input register
  always_comb begin
    rn_addr = {3'b000, psw[4:3], s1_opcode[2:0]};
    ri_addr = {3'b000, psw[4:3], 2'b00, s1_opcode[0]};
    rn_val  = regs[rn_addr[4:0]];
    ri_val  = regs[ri_addr[4:0]];
    if (s1_rd_addr < mdm_pkg::REG_LIMIT) begin
      rd_val = regs[s1_rd_addr[4:0]];
    end else if (s1_rd_addr == mdm_pkg::SFR_ACC) begin
      rd_val = acc;
    end else if (s1_rd_addr == mdm_pkg::SFR_PSW) begin
      rd_val = psw;
    end else if (s1_rd_addr == mdm_pkg::SFR_DPL) begin
      rd_val = dpl;
    end else if (s1_rd_addr == mdm_pkg::SFR_DPH) begin
      rd_val = dph;
    end else if (byp_hit) begin
      rd_val = byp_data;
    end else begin
      rd_val = rd_q;
    end
    bit_mask = 8'd1 << s1_first[2:0];
    bit_val  = |(rd_val & bit_mask);
  end

  // Execute the word: pick the write, status and charged cycles
  always_comb begin
    wen          = 1'b0;
    dptr_wen     = 1'b0;
    waddr        = mdm_pkg::SFR_ACC;
    wdata        = 8'd0;
    cyc          = 2'd0;
    caddr        = 16'd0;
    st           = mdm_pkg::ST_DONE;
    pending_next = pending;
    if (s1_command) begin
      if (!pending) begin
        st = mdm_pkg::ST_PROTO;
      end else begin
        wen          = 1'b1;
        wdata        = s1_code;
        pending_next = 1'b0;
      end
    end else if (pending) begin
      st = mdm_pkg::ST_PROTO;
    end else begin
      cyc = s1_dec.cycles;
      unique case (s1_dec.kind)
        mdm_pkg::OP_NOP: ;
        mdm_pkg::OP_RN_IMM: begin
          wen = 1'b1; waddr = rn_addr; wdata = s1_first;
        end
        mdm_pkg::OP_A_RN: begin
          wen = 1'b1; wdata = rn_val;
        end
        mdm_pkg::OP_RN_A: begin
          wen = 1'b1; waddr = rn_addr; wdata = acc;
        end
        mdm_pkg::OP_RN_DIR: begin
          wen = 1'b1; waddr = rn_addr; wdata = rd_val;
        end
        mdm_pkg::OP_DIR_RN: begin
          wen = 1'b1; waddr = s1_first; wdata = rn_val;
        end
        mdm_pkg::OP_A_IMM: begin
          wen = 1'b1; wdata = s1_first;
        end
        mdm_pkg::OP_A_DIR: begin
          wen = 1'b1; wdata = rd_val;
        end
        mdm_pkg::OP_DIR_A: begin
          wen = 1'b1; waddr = s1_first; wdata = acc;
        end
        mdm_pkg::OP_DIR_DIR: begin
          wen = 1'b1; waddr = s1_second; wdata = rd_val;
        end
        mdm_pkg::OP_DIR_IMM: begin
          wen = 1'b1; waddr = s1_first; wdata = s1_second;
        end
        mdm_pkg::OP_IND_IMM: begin
          wen = 1'b1; waddr = ri_val; wdata = s1_first;
        end
        mdm_pkg::OP_A_IND: begin
          wen = 1'b1; wdata = rd_val;
        end
        mdm_pkg::OP_IND_A: begin
          wen = 1'b1; waddr = ri_val; wdata = acc;
        end
        mdm_pkg::OP_IND_DIR: begin
          wen = 1'b1; waddr = ri_val; wdata = rd_val;
        end
        mdm_pkg::OP_DIR_IND: begin
          wen = 1'b1; waddr = s1_first; wdata = rd_val;
        end
        mdm_pkg::OP_DPTR_IMM: dptr_wen = 1'b1;
        mdm_pkg::OP_C_BIT: begin
          wen = 1'b1; waddr = mdm_pkg::SFR_PSW; wdata = {bit_val, psw[6:0]};
        end
        mdm_pkg::OP_BIT_C: begin
          wen   = 1'b1;
          waddr = s1_rd_addr;
          wdata = psw[7] ? (rd_val | bit_mask) : (rd_val & ~bit_mask);
        end
        mdm_pkg::OP_MOVC_DPTR: begin
          caddr = {8'd0, acc} + {dph, dpl};
          st = mdm_pkg::ST_PENDING; pending_next = 1'b1;
        end
        mdm_pkg::OP_MOVC_PC: begin
          caddr = {8'd0, acc} + s1_pc;
          st = mdm_pkg::ST_PENDING; pending_next = 1'b1;
        end
        default: st = mdm_pkg::ST_BAD_OP;
      endcase
    end
    total_next = total + {46'd0, cyc};
  end

  // Forward the write to the architectural registers shown in the result
  always_comb begin
    acc_next = (wen && waddr == mdm_pkg::SFR_ACC) ? wdata : acc;
    psw_next = (wen && waddr == mdm_pkg::SFR_PSW) ? wdata : psw;
    dpl_next = dptr_wen ? s1_second :
               ((wen && waddr == mdm_pkg::SFR_DPL) ? wdata : dpl);
    dph_next = dptr_wen ? s1_first :
               ((wen && waddr == mdm_pkg::SFR_DPH) ? wdata : dph);
  end

  // Update the register banks and the architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0;
      psw <= 8'd0;
      dpl <= 8'd0;
      dph <= 8'd0;
      for (int i = 0; i < mdm_pkg::REG_BYTES; i++) regs[i] <= 8'd0;
    end else if (adv) begin
      acc <= acc_next;
      psw <= psw_next;
      dpl <= dpl_next;
      dph <= dph_next;
      if (wen && waddr < mdm_pkg::REG_LIMIT) regs[waddr[4:0]] <= wdata;
    end
  end

  // Step the clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= 8'd0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 8'd1;
      if (clr_addr == mdm_pkg::CLEAR_LAST) clearing <= 1'b0;
    end
  end

  // Write one byte and read one byte of the memory per cycle
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (adv && wen) begin
      mem[waddr] <= wdata;
    end
    if (accept) rd_q <= mem[rd_addr_in];
  end

  // Load the input register, noting a write that lands with the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_command <= command;
      s1_opcode  <= opcode;
      s1_first   <= operand_first;
      s1_second  <= operand_second;
      s1_pc      <= next_pc;
      s1_code    <= code_byte;
      s1_dec     <= dec;
      s1_rd_addr <= rd_addr_in;
      byp_hit    <= adv && wen && (waddr == rd_addr_in);
      byp_data   <= wdata;
    end
  end

  // Hold control state: pending request, cycle total, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      total     <= 48'd0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        pending   <= pending_next;
        total     <= total_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (adv) begin
      status       <= st;
      cycles       <= cyc;
      code_address <= caddr;
      acc_value    <= acc_next;
      psw_value    <= psw_next;
      dptr_value   <= {dph_next, dpl_next};
      time_total   <= total_next;
    end
  end

  `MDM_ASSERT_NEXT(a_pend_kept, clk, rst, adv && !s1_command && pending, pending)
  `MDM_ASSERT_NEXT(a_pend_done, clk, rst, adv && s1_command && pending, !pending)
  `MDM_ASSERT_NEXT(a_movc_sets, clk, rst, adv && st == mdm_pkg::ST_PENDING, pending && cycles == 2'd2)
  `MDM_ASSERT_NOW(a_bad_free, clk, rst, out_valid && status != mdm_pkg::ST_DONE && status != mdm_pkg::ST_PENDING, cycles == 2'd0)

endmodule

// File: tb/sv/mcs51_data_move_checker.sv
`timescale 1ns / 1ps

module mcs51_data_move_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [7:0]  opcode,
  input  logic [7:0]  operand_first,
  input  logic [7:0]  operand_second,
  input  logic [15:0] next_pc,
  input  logic [7:0]  code_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [1:0]  cycles,
  input  logic [15:0] code_address,
  input  logic [7:0]  acc_value,
  input  logic [7:0]  psw_value,
  input  logic [15:0] dptr_value,
  input  logic [47:0] time_total,
  output int          fail_count,
  output int          words_waiting
);

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  cycles;
    logic [15:0] code_address;
    logic [7:0]  acc;
    logic [7:0]  psw;
    logic [15:0] dptr;
    logic [47:0] total;
  } move_result_t;

  localparam logic [7:0] CARRY_MASK = 8'h80;

  logic [7:0]   mem_model [mdm_pkg::MEM_BYTES];
  logic         read_waiting;
  logic [47:0]  total_model;
  move_result_t result_queue [$];

  assign words_waiting = result_queue.size();

  // Bank-relative register address from PSW.RS1:RS0
  function automatic logic [7:0] bank_reg(input logic [2:0] n);
    return {3'b000, mem_model[mdm_pkg::SFR_PSW][4:3], n};
  endfunction

  function automatic logic [7:0] bit_home(input logic [7:0] b);
    return b[7] ? {b[7:3], 3'b000} : (8'h20 + {3'b000, b[7:3]});
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Advance the model by one accepted word and queue its result
  task automatic execute_move();
    move_result_t r;
    logic [7:0] a, ri, bb;
    logic [1:0] st, cy;
    logic [15:0] ca;
    a = mem_model[mdm_pkg::SFR_ACC];
    st = mdm_pkg::ST_DONE; cy = 2'd0; ca = 16'd0;
    if (command) begin
      if (!read_waiting) st = mdm_pkg::ST_PROTO;
      else begin
        mem_model[mdm_pkg::SFR_ACC] = code_byte;
        read_waiting = 1'b0;
      end
    end else if (read_waiting) begin
      st = mdm_pkg::ST_PROTO;
    end else begin
      ri = mem_model[bank_reg({2'b00, opcode[0]})];
      bb = bit_home(operand_first);
      if (opcode >= 8'h78 && opcode <= 8'h7F) begin
        mem_model[bank_reg(opcode[2:0])] = operand_first; cy = 2'd1;
      end else if (opcode >= 8'hE8 && opcode <= 8'hEF) begin
        mem_model[mdm_pkg::SFR_ACC] = mem_model[bank_reg(opcode[2:0])]; cy = 2'd1;
      end else if (opcode >= 8'hF8) begin
        mem_model[bank_reg(opcode[2:0])] = a; cy = 2'd1;
      end else if (opcode >= 8'hA8 && opcode <= 8'hAF) begin
        mem_model[bank_reg(opcode[2:0])] = mem_model[operand_first]; cy = 2'd2;
      end else if (opcode >= 8'h88 && opcode <= 8'h8F) begin
        mem_model[operand_first] = mem_model[bank_reg(opcode[2:0])]; cy = 2'd2;
      end else begin
        case (opcode)
          8'h00: cy = 2'd1;
          8'h74: begin mem_model[mdm_pkg::SFR_ACC] = operand_first; cy = 2'd1; end
          8'hE5: begin mem_model[mdm_pkg::SFR_ACC] = mem_model[operand_first]; cy = 2'd1; end
          8'hF5: begin mem_model[operand_first] = a; cy = 2'd1; end
          8'h85: begin mem_model[operand_second] = mem_model[operand_first]; cy = 2'd2; end
          8'h75: begin mem_model[operand_first] = operand_second; cy = 2'd2; end
          8'h76, 8'h77: begin mem_model[ri] = operand_first; cy = 2'd1; end
          8'hE6, 8'hE7: begin mem_model[mdm_pkg::SFR_ACC] = mem_model[ri]; cy = 2'd1; end
          8'hF6, 8'hF7: begin mem_model[ri] = a; cy = 2'd1; end
          8'hA6, 8'hA7: begin mem_model[ri] = mem_model[operand_first]; cy = 2'd2; end
          8'h86, 8'h87: begin mem_model[operand_first] = mem_model[ri]; cy = 2'd2; end
          8'h90: begin
            mem_model[mdm_pkg::SFR_DPH] = operand_first;
            mem_model[mdm_pkg::SFR_DPL] = operand_second; cy = 2'd2;
          end
          8'hA2: begin
            if (mem_model[bb][operand_first[2:0]])
              mem_model[mdm_pkg::SFR_PSW] = mem_model[mdm_pkg::SFR_PSW] | CARRY_MASK;
            else
              mem_model[mdm_pkg::SFR_PSW] = mem_model[mdm_pkg::SFR_PSW] & ~CARRY_MASK;
            cy = 2'd1;
          end
          8'h92: begin
            mem_model[bb][operand_first[2:0]] = mem_model[mdm_pkg::SFR_PSW][7]; cy = 2'd1;
          end
          8'h93: begin
            ca = {8'h00, a} + {mem_model[mdm_pkg::SFR_DPH], mem_model[mdm_pkg::SFR_DPL]};
            read_waiting = 1'b1; st = mdm_pkg::ST_PENDING; cy = 2'd2;
          end
          8'h83: begin
            ca = {8'h00, a} + next_pc;
            read_waiting = 1'b1; st = mdm_pkg::ST_PENDING; cy = 2'd2;
          end
          default: st = mdm_pkg::ST_BAD_OP;
        endcase
      end
    end
    total_model = total_model + {46'd0, cy};
    r.status = st; r.cycles = cy; r.code_address = ca;
    r.acc = mem_model[mdm_pkg::SFR_ACC]; r.psw = mem_model[mdm_pkg::SFR_PSW];
    r.dptr = {mem_model[mdm_pkg::SFR_DPH], mem_model[mdm_pkg::SFR_DPL]};
    r.total = total_model;
    result_queue.push_back(r);
  endtask

  // Compare each taken word against the oldest prediction
  task automatic check_word();
    move_result_t w;
    if (result_queue.size() == 0) begin
      report("unexpected result word", 64'd1, 64'd0);
    end else begin
      w = result_queue.pop_front();
      if (status != w.status) report("status", status, w.status);
      if (cycles != w.cycles) report("cycles", cycles, w.cycles);
      if (code_address != w.code_address) report("code_address", code_address, w.code_address);
      if (acc_value != w.acc) report("acc_value", acc_value, w.acc);
      if (psw_value != w.psw) report("psw_value", psw_value, w.psw);
      if (dptr_value != w.dptr) report("dptr_value", dptr_value, w.dptr);
      if (time_total != w.total) report("time_total", time_total, w.total);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mdm_pkg::MEM_BYTES; i++) mem_model[i] = 8'h00;
      read_waiting = 1'b0;
      total_model = 48'd0;
      fail_count = 0;
      result_queue.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) execute_move();
    end
  end
endmodule

// File: tb/sv/tb_mcs51_data_move_unit.sv
`timescale 1ns / 1ps

module tb_mcs51_data_move_unit;
  logic        clk, rst;
  logic        in_valid, in_stall, command;
  logic [7:0]  opcode, operand_first, operand_second, code_byte;
  logic [15:0] next_pc;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status, cycles;
  logic [15:0] code_address, dptr_value;
  logic [7:0]  acc_value, psw_value;
  logic [47:0] time_total;
  int          fail_count, words_waiting;
  int          send_idle_pct, recv_idle_pct;
  int          hold_off = 0;
  int          cycle_count = 0;
  logic        hold_req;
  logic        hold_done = 1'b0;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] OP_NOP_CODE = 8'h00;
  localparam logic [7:0] OP_MOVC_DPTR_CODE = 8'h93;
  localparam logic [7:0] OP_MOVC_PC_CODE = 8'h83;

  // Opcodes of the move family
  logic [7:0] move_ops [] = '{8'h00, 8'h74, 8'hE5, 8'hF5, 8'h85, 8'h75, 8'h76, 8'h77,
                              8'hE6, 8'hE7, 8'hF6, 8'hF7, 8'hA6, 8'hA7, 8'h86, 8'h87,
                              8'h90, 8'hA2, 8'h92, 8'h93, 8'h83, 8'h78, 8'h7F, 8'hE8,
                              8'hEF, 8'hF8, 8'hFF, 8'hA8, 8'hAF, 8'h88, 8'h8F};

  mcs51_data_move_unit dut (.*);
  mcs51_data_move_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Drop the run at the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_mcs51_data_move_unit: errors");
      $finish;
    end
  end

  // Receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 40;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send(input logic cmd, input logic [7:0] op, input logic [7:0] p1,
                      input logic [7:0] p2, input logic [15:0] pc, input logic [7:0] cb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd; opcode <= op; operand_first <= p1;
    operand_second <= p2; next_pc <= pc; code_byte <= cb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    logic [7:0] op, p1, p2;
    int pick;
    pick = $urandom_range(99);
    op = (pick < 8) ? 8'($urandom) : move_ops[$urandom_range(move_ops.size() - 1)];
    // Bias addresses toward low RAM and the PSW
    p1 = ($urandom_range(3) == 0) ? 8'($urandom) :
         ($urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(3) == 0 ? 8'hD0 : 8'h20));
    p2 = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(31));
    send(($urandom_range(19) == 0), op, p1, p2, 16'($urandom), 8'($urandom));
    if (op == OP_MOVC_DPTR_CODE || op == OP_MOVC_PC_CODE)
      if ($urandom_range(9) != 0)
        send(1'b1, OP_NOP_CODE, 8'h00, 8'h00, 16'h0000, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1; clk = 1'b0; hold_req = 1'b0;
    in_valid = 1'b0; command = 1'b0; opcode = 8'h00;
    operand_first = 8'h00; operand_second = 8'h00; next_pc = 16'h0000; code_byte = 8'h00;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, banks, bits, MOVC paths and protocol errors
    send(1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h55);
    send(1'b0, 8'h74, 8'hFF, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'h75, 8'hD0, 8'h18, 16'h0000, 8'h00);
    send(1'b0, 8'h7F, 8'hAA, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'hF8, 8'h00, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'h75, 8'h20, 8'hFF, 16'h0000, 8'h00);
    send(1'b0, 8'hA2, 8'h07, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'h92, 8'hE0, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'h92, 8'h7F, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'hA2, 8'hFF, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'h90, 8'hFF, 8'hFF, 16'h0000, 8'h00);
    send(1'b0, 8'h85, 8'h82, 8'h7F, 16'h0000, 8'h00);
    send(1'b0, 8'h78, 8'hFF, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'hF6, 8'h00, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'hE7, 8'h00, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'hA5, 8'h12, 8'h34, 16'h0000, 8'h00);
    send(1'b0, 8'h93, 8'h00, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00);
    send(1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    send(1'b0, 8'h83, 8'h00, 8'h00, 16'hFFFF, 8'h00);
    send(1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00);
    send(1'b0, 8'h86, 8'h00, 8'h00, 16'h0000, 8'h00);
    drain();

    // Random phases with shifting idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 11 : 0;
      for (int i = 0; i < 170; i++) begin
        if (i == 60 && phase == 2) hold_req = 1'b1;
        send_random();
      end
      drain();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0 && words_waiting == 0) begin
      $display("tb_mcs51_data_move_unit: clean");
    end else begin
      $display("tb_mcs51_data_move_unit: errors");
    end
    $finish;
  end
endmodule
